// ===== rtl/core/masked_descriptor_filter_assert.svh =====
`ifndef MASKED_DESCRIPTOR_FILTER_ASSERT_SVH
`define MASKED_DESCRIPTOR_FILTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mdf_pkg.sv =====
package mdf_pkg;

  localparam int ENTRY_BYTES = 8;
  localparam int ACTIVE_W    = 4;
  localparam int OFFSET_W    = 12;
  localparam int INDEX_W     = 3;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic        section_end;
    logic [2:0]  entry_index;
    logic [7:0]  entry_tag;
    logic [3:0]  entry_mask_len;
    logic [63:0] entry_mask;
    logic [63:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          desc_tag;
    logic [7:0]          desc_length;
    logic [OFFSET_W-1:0] desc_offset;
    logic                matched;
    logic [INDEX_W-1:0]  match_index;
    logic                truncated;
  } out_item_t;

endpackage

// ===== rtl/core/masked_descriptor_filter.sv =====
// A result enters the output register, or the skid stage, when the byte ending its
// descriptor is accepted. Throughput: one data byte per cycle; with a result stalled
// in the output, the next finished descriptor holds the input until the output moves.
// A load writes min(MASK_BYTES, 8) pattern rows: row 0 at its beat, the rest in a stall.
// Reset (rst, synchronous): parser, active count, filter tags and mask lengths clear;
// the pattern memory is not cleared and needs no clearing pass.
`include "masked_descriptor_filter_assert.svh"

module masked_descriptor_filter #(
  parameter int MAX_FILTERS   = 8,
  parameter int MASK_BYTES    = 8,
  parameter int SECTION_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mdf_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mdf_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mdf_pkg::ACTIVE_W-1:0]  cfg_data
);
  import mdf_pkg::*;

  localparam int LIM = (MASK_BYTES < ENTRY_BYTES) ? MASK_BYTES : ENTRY_BYTES;
  localparam int RW  = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int LW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int PW  = $clog2(SECTION_BYTES);

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_BODY} phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             cur_tag, cur_tag_next;
  logic [7:0]             cur_len, cur_len_next;
  logic [7:0]             body_count, body_count_next;
  logic [PW-1:0]          pos, pos_next;
  logic [PW-1:0]          start, start_next;
  logic [MAX_FILTERS-1:0] alive, alive_next;
  logic [ACTIVE_W-1:0]    active;

  logic [7:0]             filt_tag  [MAX_FILTERS];
  logic [3:0]             filt_mlen [MAX_FILTERS];
  logic [MAX_FILTERS-1:0] lane_on;

  logic [15:0]            pat_mem [LIM][MAX_FILTERS];
  logic [15:0]            pat_rd  [MAX_FILTERS];
  logic [RW-1:0]          rd_addr;
  logic                   wr_en;
  logic [RW-1:0]          wr_row;
  logic [LW-1:0]          wr_lane;
  logic [15:0]            wr_data;

  logic                   sweep_busy;
  logic [RW-1:0]          sweep_row;
  logic [LW-1:0]          sweep_lane;
  logic [63:0]            sweep_mask;
  logic [63:0]            sweep_value;

  logic                   data_acc, load_acc;
  logic [7:0]             b;
  logic                   sec_end;
  logic                   emit, emit_trunc;
  logic [7:0]             emit_len;
  logic                   hit;
  logic [LW-1:0]          hit_lane;
  out_item_t              res_data;

  logic                   skid_valid;
  out_item_t              skid_data;

  assign in_stall  = sweep_busy || skid_valid;
  assign cfg_ready = 1'b1;
  assign data_acc  = in_valid && !in_stall && (in_data.cmd == CMD_DATA);
  assign load_acc  = in_valid && !in_stall && (in_data.cmd == CMD_LOAD)
                     && (int'(in_data.entry_index) < MAX_FILTERS);
  assign b         = in_data.data_byte;
  assign sec_end   = in_data.section_end;

  always_comb begin
    for (int k = 0; k < MAX_FILTERS; k++) begin
      lane_on[k] = int'(active) > k;
    end
  end

  // parse next state
  always_comb begin
    phase_next      = phase;
    cur_tag_next    = cur_tag;
    cur_len_next    = cur_len;
    body_count_next = body_count;
    pos_next        = pos;
    start_next      = start;
    alive_next      = alive;
    emit            = 1'b0;
    emit_trunc      = 1'b0;
    emit_len        = cur_len;
    if (data_acc) begin
      unique case (phase)
        PH_LEN: begin
          cur_len_next    = b;
          body_count_next = 8'd0;
          for (int k = 0; k < MAX_FILTERS; k++) begin
            alive_next[k] = lane_on[k] && (filt_tag[k] == cur_tag)
                            && ({4'd0, filt_mlen[k]} <= b);
          end
          if (b == 8'd0) begin
            emit       = 1'b1;
            emit_len   = 8'd0;
            phase_next = PH_TAG;
          end else begin
            phase_next = PH_BODY;
            if (sec_end) begin
              emit       = 1'b1;
              emit_trunc = 1'b1;
              emit_len   = b;
            end
          end
        end
        PH_BODY: begin
          for (int k = 0; k < MAX_FILTERS; k++) begin
            if (alive[k] && ({4'd0, filt_mlen[k]} > body_count)
                && (((b ^ pat_rd[k][15:8]) & pat_rd[k][7:0]) != 8'd0)) begin
              alive_next[k] = 1'b0;
            end
          end
          body_count_next = body_count + 8'd1;
          if (body_count_next == cur_len) begin
            emit       = 1'b1;
            phase_next = PH_TAG;
          end else if (sec_end) begin
            emit       = 1'b1;
            emit_trunc = 1'b1;
          end
        end
        PH_TAG: begin
          cur_tag_next    = b;
          cur_len_next    = 8'd0;
          body_count_next = 8'd0;
          alive_next      = '0;
          start_next      = pos;
          phase_next      = PH_LEN;
          if (sec_end) begin
            emit       = 1'b1;
            emit_trunc = 1'b1;
            emit_len   = 8'd0;
          end
        end
        default: phase_next = PH_TAG;
      endcase
      if (sec_end) begin
        phase_next = PH_TAG;
        pos_next   = '0;
      end else if (int'(pos) == SECTION_BYTES - 1) begin
        pos_next = '0;
      end else begin
        pos_next = pos + PW'(1);
      end
    end
  end

  // lowest surviving filter
  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int k = MAX_FILTERS - 1; k >= 0; k--) begin
      if (alive_next[k] && !emit_trunc) begin
        hit      = 1'b1;
        hit_lane = LW'(k);
      end
    end
  end

  always_comb begin
    res_data.desc_tag    = cur_tag_next;
    res_data.desc_length = emit_len;
    res_data.desc_offset = OFFSET_W'(start_next);
    res_data.matched     = hit;
    res_data.match_index = hit ? INDEX_W'(hit_lane) : '0;
    res_data.truncated   = emit_trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      cur_tag    <= '0;
      cur_len    <= '0;
      body_count <= '0;
      pos        <= '0;
      start      <= '0;
      alive      <= '0;
    end else begin
      phase      <= phase_next;
      cur_tag    <= cur_tag_next;
      cur_len    <= cur_len_next;
      body_count <= body_count_next;
      pos        <= pos_next;
      start      <= start_next;
      alive      <= alive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_FILTERS; k++) begin
        filt_tag[k]  <= '0;
        filt_mlen[k] <= '0;
      end
    end else if (load_acc) begin
      filt_tag[LW'(in_data.entry_index)]  <= in_data.entry_tag;
      filt_mlen[LW'(in_data.entry_index)] <= (int'(in_data.entry_mask_len) > LIM) ?
                                             4'(LIM) : in_data.entry_mask_len;
    end
  end

  // load sweep: row 0 at the command beat, remaining rows while input holds
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_busy <= 1'b0;
    end else if (load_acc) begin
      sweep_busy <= (LIM > 1);
    end else if (sweep_busy && (int'(sweep_row) == LIM - 1)) begin
      sweep_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      sweep_row   <= RW'(1);
      sweep_lane  <= LW'(in_data.entry_index);
      sweep_mask  <= in_data.entry_mask;
      sweep_value <= in_data.entry_value;
    end else if (sweep_busy) begin
      sweep_row <= sweep_row + RW'(1);
    end
  end

  always_comb begin
    if (load_acc) begin
      wr_en   = 1'b1;
      wr_row  = '0;
      wr_lane = LW'(in_data.entry_index);
      wr_data = {in_data.entry_value[7:0], in_data.entry_mask[7:0]};
    end else begin
      wr_en   = sweep_busy;
      wr_row  = sweep_row;
      wr_lane = sweep_lane;
      wr_data = {sweep_value[{sweep_row, 3'b000} +: 8], sweep_mask[{sweep_row, 3'b000} +: 8]};
    end
  end

  assign rd_addr = (int'(body_count_next) < LIM) ? body_count_next[RW-1:0] : '0;

  // pattern memory: row per body byte, lane per filter; forward a same-row write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_mem[wr_row][wr_lane] <= wr_data;
    end
    for (int k = 0; k < MAX_FILTERS; k++) begin
      pat_rd[k] <= (wr_en && (wr_row == rd_addr) && (wr_lane == LW'(k))) ?
                   wr_data : pat_mem[rd_addr][k];
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_data <= skid_valid ? skid_data : res_data;
    end else if (emit) begin
      skid_data <= res_data;
    end
  end

  `MDF_ASSERT_NOW(a_skid_behind_head, skid_valid, out_valid, "skid beat without head beat")
  `MDF_ASSERT_NOW(a_sweep_holds_input, sweep_busy, in_stall, "input open during load sweep")
  `MDF_ASSERT_NOW(a_trunc_no_match, out_valid && out_data.truncated,
                  !out_data.matched && (out_data.match_index == '0), "truncated beat matched")
  `MDF_ASSERT_NEXT(a_end_restarts, in_valid && !in_stall && (in_data.cmd == CMD_DATA)
                   && in_data.section_end, (phase == PH_TAG) && (pos == '0),
                   "parser not restarted after section end")

endmodule

// ===== tb/sv/descriptor_result_checker.sv =====
module descriptor_result_checker #(
  parameter int MAX_FILTERS = 8,
  parameter int MASK_BYTES  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  mdf_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  mdf_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [mdf_pkg::ACTIVE_W-1:0] cfg_data,
  output int                           expected_left,
  output int                           failures,
  output int                           results_checked,
  output int                           hits_seen,
  output int                           cuts_seen
);
  import mdf_pkg::*;

  localparam int MASK_LIMIT = (MASK_BYTES < ENTRY_BYTES) ? MASK_BYTES : ENTRY_BYTES;

  typedef enum logic [1:0] {
    EXPECT_TAG,
    EXPECT_LEN,
    EXPECT_BODY
  } parse_state_t;

  parse_state_t         parse_state;
  logic [7:0]           cur_tag;
  logic [7:0]           cur_len;
  logic [7:0]           body_cnt;
  logic [OFFSET_W-1:0]  position;
  logic [OFFSET_W-1:0]  desc_start;
  logic [MAX_FILTERS-1:0] alive;
  logic [ACTIVE_W-1:0]  filters_in_use;
  logic [7:0]           entry_tag      [MAX_FILTERS];
  logic [3:0]           entry_mask_len [MAX_FILTERS];
  logic [63:0]          entry_mask     [MAX_FILTERS];
  logic [63:0]          entry_value    [MAX_FILTERS];

  out_item_t expected_descriptors[$];

  function automatic int live_count();
    return (int'(filters_in_use) > MAX_FILTERS) ? MAX_FILTERS : int'(filters_in_use);
  endfunction

  function automatic out_item_t build_descriptor_result(input bit cut, input logic [7:0] len);
    out_item_t r;
    r = '0;
    r.desc_tag    = cur_tag;
    r.desc_length = len;
    r.desc_offset = desc_start;
    r.truncated   = cut;
    if (!cut) begin
      for (int k = MAX_FILTERS - 1; k >= 0; k--) begin
        if (alive[k]) begin
          r.matched     = 1'b1;
          r.match_index = k[INDEX_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic string show(input out_item_t r);
    return $sformatf("tag %02h len %0d off %0d matched %0b idx %0d trunc %0b",
                     r.desc_tag, r.desc_length, r.desc_offset, r.matched,
                     r.match_index, r.truncated);
  endfunction

  task automatic reset_predictor();
    parse_state    = EXPECT_TAG;
    cur_tag        = '0;
    cur_len        = '0;
    body_cnt       = '0;
    position       = '0;
    desc_start     = '0;
    alive          = '0;
    filters_in_use = '0;
    for (int k = 0; k < MAX_FILTERS; k++) begin
      entry_tag[k]      = '0;
      entry_mask_len[k] = '0;
      entry_mask[k]     = '0;
      entry_value[k]    = '0;
    end
    expected_descriptors.delete();
  endtask

  task automatic advance_parser(input in_item_t beat);
    logic [7:0] b;
    logic [7:0] m;
    logic [7:0] v;
    int         idx;
    if (beat.cmd == CMD_LOAD) begin
      idx = int'(beat.entry_index);
      if (idx < MAX_FILTERS) begin
        entry_tag[idx]      = beat.entry_tag;
        entry_mask_len[idx] = (int'(beat.entry_mask_len) > MASK_LIMIT) ? 4'(MASK_LIMIT)
                                                                       : beat.entry_mask_len;
        entry_mask[idx]     = beat.entry_mask;
        entry_value[idx]    = beat.entry_value;
      end
      return;
    end
    b = beat.data_byte;
    case (parse_state)
      EXPECT_LEN: begin
        cur_len  = b;
        body_cnt = '0;
        alive    = '0;
        for (int k = 0; k < live_count(); k++) begin
          if (entry_tag[k] == cur_tag && {4'd0, entry_mask_len[k]} <= b) alive[k] = 1'b1;
        end
        if (b == 8'd0) begin
          expected_descriptors.push_back(build_descriptor_result(1'b0, 8'd0));
          parse_state = EXPECT_TAG;
        end else begin
          parse_state = EXPECT_BODY;
          if (beat.section_end)
            expected_descriptors.push_back(build_descriptor_result(1'b1, b));
        end
      end
      EXPECT_BODY: begin
        for (int k = 0; k < MAX_FILTERS; k++) begin
          if (alive[k] && body_cnt < {4'd0, entry_mask_len[k]}
              && int'(body_cnt) < ENTRY_BYTES) begin
            m = entry_mask[k][8*body_cnt +: 8];
            v = entry_value[k][8*body_cnt +: 8];
            if (((b ^ v) & m) != 8'd0) alive[k] = 1'b0;
          end
        end
        body_cnt = body_cnt + 8'd1;
        if (body_cnt == cur_len) begin
          expected_descriptors.push_back(build_descriptor_result(1'b0, cur_len));
          parse_state = EXPECT_TAG;
        end else if (beat.section_end) begin
          expected_descriptors.push_back(build_descriptor_result(1'b1, cur_len));
        end
      end
      default: begin
        cur_tag     = b;
        cur_len     = '0;
        body_cnt    = '0;
        alive       = '0;
        desc_start  = position;
        parse_state = EXPECT_LEN;
        if (beat.section_end)
          expected_descriptors.push_back(build_descriptor_result(1'b1, 8'd0));
      end
    endcase
    if (beat.section_end) begin
      parse_state = EXPECT_TAG;
      position    = '0;
    end else begin
      position = position + OFFSET_W'(1);
    end
  endtask

  task automatic check_descriptor(input out_item_t got);
    out_item_t want;
    string     bad;
    if (expected_descriptors.size() == 0) begin
      failures++;
      if (failures <= 10) $display("[%0t] result with nothing expected: %s", $time, show(got));
      return;
    end
    want = expected_descriptors.pop_front();
    results_checked++;
    if (want.matched) hits_seen++;
    if (want.truncated) cuts_seen++;
    bad = "";
    if (got.desc_tag !== want.desc_tag) bad = {bad, " desc_tag"};
    if (got.desc_length !== want.desc_length) bad = {bad, " desc_length"};
    if (got.desc_offset !== want.desc_offset) bad = {bad, " desc_offset"};
    if (got.matched !== want.matched) bad = {bad, " matched"};
    if (got.match_index !== want.match_index) bad = {bad, " match_index"};
    if (got.truncated !== want.truncated) bad = {bad, " truncated"};
    if (bad != "") begin
      failures++;
      if (failures <= 10) begin
        $display("[%0t] descriptor mismatch in%s", $time, bad);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_predictor();
    end else begin
      if (out_valid && !out_stall) check_descriptor(out_data);
      if (cfg_valid && cfg_ready) filters_in_use = cfg_data;
      if (in_valid && !in_stall) advance_parser(in_data);
    end
    expected_left <= expected_descriptors.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import mdf_pkg::*;

  localparam int MAX_FILTERS   = 8;
  localparam int MASK_BYTES    = 8;
  localparam int SECTION_BYTES = 4096;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_BEATS   = 150;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACTIVE_W-1:0] cfg_data = '0;

  int expected_left;
  int failures;
  int results_checked;
  int hits_seen;
  int cuts_seen;

  bit idling_on = 1'b1;
  int beats_sent;
  int loads_sent;
  int settings_used;

  logic [7:0]  filt_tag      [MAX_FILTERS];
  logic [3:0]  filt_mask_len [MAX_FILTERS];
  logic [63:0] filt_mask     [MAX_FILTERS];
  logic [63:0] filt_value    [MAX_FILTERS];
  logic [7:0]  section_bytes [$];

  logic [ACTIVE_W-1:0] presets [7] = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8, 4'd3};

  masked_descriptor_filter #(
    .MAX_FILTERS  (MAX_FILTERS),
    .MASK_BYTES   (MASK_BYTES),
    .SECTION_BYTES(SECTION_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  descriptor_result_checker #(
    .MAX_FILTERS(MAX_FILTERS),
    .MASK_BYTES (MASK_BYTES)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .expected_left  (expected_left),
    .failures       (failures),
    .results_checked(results_checked),
    .hits_seen      (hits_seen),
    .cuts_seen      (cuts_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < 35);
  end

  function automatic in_item_t random_fields();
    in_item_t beat;
    beat.cmd            = 1'($urandom_range(1));
    beat.data_byte      = 8'($urandom_range(255));
    beat.section_end    = 1'($urandom_range(1));
    beat.entry_index    = 3'($urandom_range(7));
    beat.entry_tag      = 8'($urandom_range(255));
    beat.entry_mask_len = 4'($urandom_range(15));
    beat.entry_mask     = {$urandom, $urandom};
    beat.entry_value    = {$urandom, $urandom};
    return beat;
  endfunction

  function automatic logic [7:0] pick_tag();
    return $urandom_range(1) ? 8'h40 + 8'($urandom_range(2)) : 8'($urandom_range(255));
  endfunction

  task automatic send_beat(input in_item_t beat);
    if (idling_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (beat.cmd == CMD_LOAD) loads_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value, input bit last);
    in_item_t beat;
    beat             = random_fields();
    beat.cmd         = CMD_DATA;
    beat.data_byte   = value;
    beat.section_end = last;
    send_beat(beat);
  endtask

  task automatic load_entry(input int idx, input logic [7:0] tag, input logic [3:0] mlen,
                            input logic [63:0] mask, input logic [63:0] value);
    in_item_t beat;
    beat                = random_fields();
    beat.cmd            = CMD_LOAD;
    beat.entry_index    = idx[2:0];
    beat.entry_tag      = tag;
    beat.entry_mask_len = mlen;
    beat.entry_mask     = mask;
    beat.entry_value    = value;
    filt_tag[idx]       = tag;
    filt_mask_len[idx]  = mlen;
    filt_mask[idx]      = mask;
    filt_value[idx]     = value;
    send_beat(beat);
  endtask

  task automatic load_random_entry();
    logic [63:0] mask;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(2))
        0:       mask[8*i +: 8] = 8'hFF;
        1:       mask[8*i +: 8] = 8'h00;
        default: mask[8*i +: 8] = 8'($urandom_range(255));
      endcase
    end
    load_entry(int'($urandom_range(MAX_FILTERS - 1)), pick_tag(), 4'($urandom_range(15)),
               mask, {$urandom, $urandom});
  endtask

  task automatic write_active(input logic [ACTIVE_W-1:0] count);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_descriptor(input bit big);
    int         k;
    int         len;
    int         need;
    bit         hit;
    logic [7:0] tag;
    logic [7:0] m;
    logic [7:0] v;
    k    = $urandom_range(MAX_FILTERS - 1);
    need = (int'(filt_mask_len[k]) > 8) ? 8 : int'(filt_mask_len[k]);
    hit  = $urandom_range(99) < 70;
    if (hit) begin
      tag = filt_tag[k];
      len = need + $urandom_range(3);
      if (need > 0 && $urandom_range(9) == 0) len = $urandom_range(need - 1);
    end else begin
      tag = 8'($urandom_range(255));
      len = $urandom_range(10);
    end
    if (big) len = $urandom_range(255, 120);
    else if ($urandom_range(49) == 0) len = $urandom_range(255);
    section_bytes.push_back(tag);
    section_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      if (hit && i < need && $urandom_range(9) != 0) begin
        m = filt_mask[k][8*i +: 8];
        v = filt_value[k][8*i +: 8];
        section_bytes.push_back((v & m) | (8'($urandom_range(255)) & ~m));
      end else begin
        section_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_section(input int count, input bit big);
    int cut;
    section_bytes.delete();
    repeat (count) add_descriptor(big);
    cut = section_bytes.size() - 1;
    if ($urandom_range(99) < 15) cut = $urandom_range(section_bytes.size() - 1);
    for (int i = 0; i <= cut; i++) begin
      if ($urandom_range(99) < 3) load_random_entry();
      send_byte(section_bytes[i], i == cut);
    end
  endtask

  task automatic send_noise();
    int count;
    count = $urandom_range(24, 1);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) load_random_entry();
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int  start;
    bit  paused;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_active(4'd0);

    // zero length at offset 0, then a section cut right at the tag
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    load_entry(0, 8'h40, 4'd2, '1, 64'h0123_4567_89AB_CDEF);
    load_entry(1, 8'h41, 4'd15, '1, '0);
    load_entry(2, 8'h41, 4'd0, '0, '1);
    load_entry(3, 8'h41, 4'd0, 64'h5A5A_5A5A_5A5A_5A5A, 64'hC3C3_C3C3_C3C3_C3C3);
    load_entry(4, 8'h00, 4'd8, 64'hF0F0_F0F0_F0F0_F0F0, 64'hA5A5_A5A5_A5A5_A5A5);
    load_entry(5, 8'hFF, 4'd1, 64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FF80);
    load_entry(6, 8'h42, 4'd4, 64'h00FF_00FF_00FF_00FF, 64'h1122_3344_5566_7788);
    load_entry(7, 8'h40, 4'd1, 64'h0F0F_0F0F_0F0F_0F0F, 64'hFFFF_FFFF_FFFF_FF0F);
    wait_for_results();
    write_active(4'd8);

    send_byte(8'h40, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hCD, 1'b0);
    // entry 1 too long for this descriptor, entries 2 and 3 tie
    send_byte(8'h41, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h03, 1'b1);
    // reload entry 0 between body bytes so entry 7 takes over
    send_byte(8'h40, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hEF, 1'b0);
    load_entry(0, 8'h40, 4'd2, '1, '0);
    send_byte(8'hCD, 1'b1);

    for (int p = 0; p < 7; p++) begin
      wait_for_results();
      write_active(presets[p]);
      idling_on = (p != 2);
      if (p == 4) send_section(3, 1'b1);
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) begin
        if (p == 5 && !paused && beats_sent - start > PHASE_BEATS / 2) begin
          wait_for_results();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 8) send_noise();
        else send_section($urandom_range(5, 1), 1'b0);
      end
    end
    idling_on = 1'b1;
    wait_for_results();

    $display("Drove %0d beats (%0d table loads) under %0d filter-count settings.",
             beats_sent, loads_sent, settings_used);
    $display("Checked %0d descriptors: %0d matched, %0d truncated.",
             results_checked, hits_seen, cuts_seen);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
